@@ hw/rtl/iiad_pkg.sv @@
`default_nettype none
package iiad_pkg;

  localparam int MaxWindowDef = 64;
  localparam int AxisBitsDef  = 16;

  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 17;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_WINDOW_LENGTH    = 3'd0,
    REG_ACCEL_LIMIT      = 3'd1,
    REG_GYRO_LIMIT       = 3'd2,
    REG_MAGNET_LIMIT     = 3'd3,
    REG_MAGNET_ENABLE    = 3'd4,
    REG_SMOOTHING_ENABLE = 3'd5,
    REG_SMOOTHING_WEIGHT = 3'd6
  } reg_index_t;

  localparam int ImpactMax = 4194303;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_READ,
    ST_UPDATE,
    ST_CALC,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/iiad_ram.sv @@
`default_nettype none
module iiad_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/iiad_sqrt.sv @@
`default_nettype none
// Digit-by-digit integer square root, one result bit per cycle.
module iiad_sqrt #(
  parameter int InBits = 34
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [InBits-1:0]     radicand,
  output logic                       busy,
  output logic      [InBits/2:0]     root
);
  localparam int RootBits = InBits / 2 + 1;
  localparam int RemBits  = RootBits + 2;
  localparam int CntBits  = $clog2(RootBits + 1);
  localparam int PadBits  = 2 * RootBits;

  logic [PadBits-1:0]  value;
  logic [RemBits-1:0]  rem;
  logic [CntBits-1:0]  cnt;
  logic [RemBits-1:0]  trial;
  logic [RemBits-1:0]  shifted;

  always_comb begin
    shifted = {rem[RemBits-3:0], value[PadBits-1 -: 2]};
    trial   = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntBits'(RootBits);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CntBits'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      value <= PadBits'(radicand);
      rem   <= '0;
      root  <= '0;
    end else if (busy) begin
      value <= {value[PadBits-3:0], 2'b00};
      if (shifted >= trial) begin
        rem  <= shifted - trial;
        root <= {root[RootBits-2:0], 1'b1};
      end else begin
        rem  <= shifted;
        root <= {root[RootBits-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/imu_impact_anomaly_detector_unit.sv @@
`default_nettype none
// IMU impact anomaly detector. One nine-axis sample goes in per transaction and
// one result comes out. A new sample is taken only after the last result is
// accepted: the three vector magnitudes share one bit-serial square root unit,
// then the window slot is read from and written back to a single ring memory,
// the decision is registered, the result is offered, and the unit returns to
// idle to take the next input. The window memory needs no clearing; a fill
// count tracks valid slots. Writing window_length clears the history at once.
// Configuration is taken only while idle, and a pending configuration write
// holds off the input.
module imu_impact_anomaly_detector_unit #(
  parameter int MAX_WINDOW = iiad_pkg::MaxWindowDef,
  parameter int AXIS_BITS  = iiad_pkg::AxisBitsDef
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [iiad_pkg::CfgIdxBits-1:0]  cfg_index,
  input  wire logic [iiad_pkg::CfgDataBits-1:0] cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic signed [AXIS_BITS-1:0] acc_x,
  input  wire logic signed [AXIS_BITS-1:0] acc_y,
  input  wire logic signed [AXIS_BITS-1:0] acc_z,
  input  wire logic signed [AXIS_BITS-1:0] rot_x,
  input  wire logic signed [AXIS_BITS-1:0] rot_y,
  input  wire logic signed [AXIS_BITS-1:0] rot_z,
  input  wire logic signed [AXIS_BITS-1:0] field_x,
  input  wire logic signed [AXIS_BITS-1:0] field_y,
  input  wire logic signed [AXIS_BITS-1:0] field_z,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        obstacle_found,
  output logic                        acc_anomaly,
  output logic                        rot_anomaly,
  output logic                        field_anomaly,
  output logic [6:0]                  confidence_pct,
  output logic [21:0]                 impact_hundredths,
  output logic                        history_full
);
  localparam int AB      = AXIS_BITS;
  localparam int SqBits  = 2 * AB + 2;           // sum of three squares
  localparam int MagBits = AB + 2;               // root of SqBits
  localparam int PtrBits = $clog2(MAX_WINDOW);
  localparam int NBits   = $clog2(MAX_WINDOW + 1);
  localparam int SumBits = MagBits + NBits;
  localparam int ProdBits = SumBits + 1;
  localparam int LimProd = 17 + NBits;
  localparam int BlendBits = AB + 10;

  // configuration
  logic [6:0]  window_length;
  logic [16:0] accel_limit, gyro_limit, magnet_limit;
  logic        magnet_enable, smoothing_enable;
  logic [8:0]  smoothing_weight;

  // state
  logic signed [AB-1:0] last_sample [9];
  logic signed [AB-1:0] smp [9];
  logic [SumBits-1:0]   sum [3];
  logic [NBits-1:0]     fill_count;
  logic [PtrBits-1:0]   ring_pointer;
  logic [MagBits-1:0]   mag [3];
  logic [1:0]           vec;
  logic [NBits-1:0]     n_eff;
  logic                 full;
  logic                 fa, fr, ff;

  iiad_pkg::state_t state, state_next;
  logic                 sq_start, sq_busy;

  logic                 cfg_fire, in_fire;
  logic [SqBits-1:0]    radicand;
  logic [SqBits/2:0]    root;

  assign cfg_ready = (state == iiad_pkg::ST_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = (state != iiad_pkg::ST_IDLE) || cfg_valid;
  assign in_fire   = in_valid && !in_stall;

  always_comb begin
    if (window_length == 7'd0) begin
      n_eff = NBits'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      n_eff = NBits'(MAX_WINDOW);
    end else begin
      n_eff = NBits'(window_length);
    end
  end

  // blend: floor((a*new + (256-a)*prev)/256) via arithmetic shift
  logic [8:0] alpha;
  logic signed [AB-1:0] blended [9];
  logic signed [AB-1:0] raw [9];
  assign alpha = (smoothing_weight > 9'd256) ? 9'd256 : smoothing_weight;
  assign raw[0] = acc_x;   assign raw[1] = acc_y;   assign raw[2] = acc_z;
  assign raw[3] = rot_x;   assign raw[4] = rot_y;   assign raw[5] = rot_z;
  assign raw[6] = field_x; assign raw[7] = field_y; assign raw[8] = field_z;

  always_comb begin
    logic signed [BlendBits-1:0] acc;
    for (int i = 0; i < 9; i++) begin
      acc = BlendBits'(signed'({1'b0, alpha})) * BlendBits'(raw[i])
          + BlendBits'(signed'({1'b0, 9'd256 - alpha})) * BlendBits'(last_sample[i]);
      blended[i] = (smoothing_enable && fill_count != '0)
                 ? AB'(acc >>> 8) : raw[i];
    end
  end

  // squares of the current vector
  always_comb begin
    logic signed [AB-1:0]   vx, vy, vz;
    logic signed [2*AB-1:0] p0, p1, p2;
    unique case (vec)
      2'd0: begin
        vx = smp[0]; vy = smp[1]; vz = smp[2];
      end
      2'd1: begin
        vx = smp[3]; vy = smp[4]; vz = smp[5];
      end
      default: begin
        vx = smp[6]; vy = smp[7]; vz = smp[8];
      end
    endcase
    p0 = vx * vx;
    p1 = vy * vy;
    p2 = vz * vz;
    radicand = SqBits'(unsigned'(p0)) + SqBits'(unsigned'(p1)) + SqBits'(unsigned'(p2));
  end

  iiad_sqrt #(.InBits(SqBits)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .busy     (sq_busy),
    .root     (root)
  );

  // ring memory: three magnitudes per slot
  logic [3*MagBits-1:0] ring_rdata;
  logic                 ring_we;
  iiad_ram #(.Width(3*MagBits), .Depth(MAX_WINDOW)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_pointer),
    .wdata ({mag[2], mag[1], mag[0]}),
    .raddr (ring_pointer),
    .rdata (ring_rdata)
  );

  // sequencer
  logic sqrt_launched;
  always_comb begin
    state_next = state;
    unique case (state)
      iiad_pkg::ST_IDLE:   if (in_fire) state_next = iiad_pkg::ST_SQRT;
      iiad_pkg::ST_SQRT:
        if (sqrt_launched && !sq_busy && vec == 2'd2) state_next = iiad_pkg::ST_READ;
      iiad_pkg::ST_READ:   state_next = iiad_pkg::ST_UPDATE;
      iiad_pkg::ST_UPDATE: state_next = iiad_pkg::ST_CALC;
      iiad_pkg::ST_CALC:   state_next = iiad_pkg::ST_OUT;
      iiad_pkg::ST_OUT:    if (!out_stall) state_next = iiad_pkg::ST_IDLE;
      default:             state_next = iiad_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sq_start = (state == iiad_pkg::ST_SQRT) && !sqrt_launched;
    ring_we  = (state == iiad_pkg::ST_UPDATE);
    out_valid = (state == iiad_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iiad_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sqrt launch tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_launched <= 1'b0;
      vec <= '0;
    end else if (in_fire) begin
      sqrt_launched <= 1'b0;
      vec <= '0;
    end else if (state == iiad_pkg::ST_SQRT) begin
      if (sq_start) begin
        sqrt_launched <= 1'b1;
      end else if (!sq_busy) begin
        mag[vec] <= MagBits'(root);
        if (vec != 2'd2) begin
          vec <= vec + 1'b1;
          sqrt_launched <= 1'b0;
        end
      end
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) last_sample[i] <= '0;
    end else if (in_fire) begin
      for (int i = 0; i < 9; i++) begin
        smp[i] <= blended[i];
        last_sample[i] <= blended[i];
      end
    end
  end

  // config, history update, decision
  logic [ProdBits-1:0] cur_n [3];
  logic [ProdBits-1:0] dev [3];
  logic [LimProd-1:0]  lim_n [3];
  logic [16:0]         lim [3];
  logic                hit [3];
  assign lim[0] = accel_limit;
  assign lim[1] = gyro_limit;
  assign lim[2] = magnet_limit;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cur_n[c] = ProdBits'(mag[c]) * ProdBits'(n_eff);
      dev[c] = (cur_n[c] > ProdBits'(sum[c])) ? cur_n[c] - ProdBits'(sum[c])
                                              : ProdBits'(sum[c]) - cur_n[c];
      lim_n[c] = LimProd'(lim[c]) * LimProd'(n_eff);
      hit[c] = (ProdBits + LimProd)'(dev[c]) > (ProdBits + LimProd)'(lim_n[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= 7'd16;
      accel_limit      <= 17'd4096;
      gyro_limit       <= 17'd4096;
      magnet_limit     <= 17'd4096;
      magnet_enable    <= 1'b0;
      smoothing_enable <= 1'b0;
      smoothing_weight <= 9'd128;
      fill_count       <= '0;
      ring_pointer     <= '0;
      for (int c = 0; c < 3; c++) sum[c] <= '0;
      full <= 1'b0;
      fa <= 1'b0;
      fr <= 1'b0;
      ff <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (iiad_pkg::reg_index_t'(cfg_index))
          iiad_pkg::REG_WINDOW_LENGTH: begin
            window_length <= cfg_data[6:0];
            fill_count    <= '0;
            ring_pointer  <= '0;
            for (int c = 0; c < 3; c++) sum[c] <= '0;
          end
          iiad_pkg::REG_ACCEL_LIMIT:      accel_limit <= cfg_data;
          iiad_pkg::REG_GYRO_LIMIT:       gyro_limit <= cfg_data;
          iiad_pkg::REG_MAGNET_LIMIT:     magnet_limit <= cfg_data;
          iiad_pkg::REG_MAGNET_ENABLE:    magnet_enable <= cfg_data[0];
          iiad_pkg::REG_SMOOTHING_ENABLE: smoothing_enable <= cfg_data[0];
          iiad_pkg::REG_SMOOTHING_WEIGHT: smoothing_weight <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (state == iiad_pkg::ST_UPDATE) begin
        // slot read in ST_READ is valid now
        for (int c = 0; c < 3; c++) begin
          if (fill_count >= n_eff) begin
            sum[c] <= sum[c] - SumBits'(ring_rdata[c*MagBits +: MagBits])
                    + SumBits'(mag[c]);
          end else begin
            sum[c] <= sum[c] + SumBits'(mag[c]);
          end
        end
        if (fill_count < n_eff) fill_count <= fill_count + 1'b1;
        if (NBits'(ring_pointer) + 1'b1 >= n_eff) begin
          ring_pointer <= '0;
        end else begin
          ring_pointer <= ring_pointer + 1'b1;
        end
      end
      if (state == iiad_pkg::ST_CALC) begin
        full <= (fill_count >= n_eff);
        fa <= (fill_count >= n_eff) && hit[0];
        fr <= (fill_count >= n_eff) && hit[1];
        ff <= (fill_count >= n_eff) && magnet_enable && hit[2];
      end
    end
  end

  // result formatting
  always_comb begin
    logic [6:0]  conf;
    logic [24:0] imp;
    conf = (fa ? 7'd40 : 7'd0) + (fr ? 7'd30 : 7'd0) + (ff ? 7'd30 : 7'd0);
    imp  = 25'(mag[0]) * 25'd70 + 25'(mag[1]) * 25'd3;
    obstacle_found = fa || fr || ff;
    acc_anomaly    = fa;
    rot_anomaly    = fr;
    field_anomaly  = ff;
    history_full   = full;
    confidence_pct = obstacle_found ? conf : 7'd0;
    if (!obstacle_found) begin
      impact_hundredths = '0;
    end else if (imp > 25'(iiad_pkg::ImpactMax)) begin
      impact_hundredths = 22'(iiad_pkg::ImpactMax);
    end else begin
      impact_hundredths = imp[21:0];
    end
  end
endmodule
`default_nettype wire

@@ dv/tb_imu_impact_anomaly_detector_unit.sv @@
module tb_imu_impact_anomaly_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WinMax = 64;
  localparam int IdleLimit = 40000;
  localparam int QDepth = 4096;
  localparam int HoldCycles = 3000;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, gx, gy, gz, mx, my, mz;
  } sample_t;

  typedef struct packed {
    logic        obs;
    logic        fa, fr, ff;
    logic [6:0]  conf;
    logic [21:0] impact;
    logic        full;
  } verdict_t;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic signed [15:0] acc_x = 0, acc_y = 0, acc_z = 0, rot_x = 0, rot_y = 0, rot_z = 0;
  logic signed [15:0] field_x = 0, field_y = 0, field_z = 0;
  logic out_valid, out_stall = 0;
  logic obstacle_found, acc_anomaly, rot_anomaly, field_anomaly, history_full;
  logic [6:0] confidence_pct;
  logic [21:0] impact_hundredths;

  imu_impact_anomaly_detector_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  longint win_len_r, lim_acc, lim_rot, lim_mag, mag_en, smooth_en, weight;
  longint prev_axis [9];
  longint ring_mag [WinMax][3];
  longint sum_mag [3];
  longint filled, wr_slot;

  // pending samples and expected results, filled at the tail, consumed at the head
  sample_t  sample_mem [QDepth];
  verdict_t verdict_mem [QDepth];
  int s_wr = 0, s_rd = 0;
  int v_wr = 0, v_rd = 0;
  int errors = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  bit hold_req = 0;
  bit hold_off = 0;
  int hold_cnt = 0;

  function automatic longint int_sqrt(longint n);
    longint r = 0;
    for (longint b = 64'sh4000_0000_0000_0000 >>> 0; b > 0; b = b >> 2) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic longint floor256(longint v);
    return v >>> 8;
  endfunction

  function automatic bit off_mean(longint cur, longint sum, longint n, longint lim);
    longint a = cur * n;
    longint d = (a > sum) ? a - sum : sum - a;
    return d > lim * n;
  endfunction

  function automatic void wipe_history();
    for (int i = 0; i < WinMax; i++) ring_mag[i] = '{0, 0, 0};
    sum_mag = '{0, 0, 0};
    filled = 0;
    wr_slot = 0;
  endfunction

  function automatic void apply_reg(iiad_pkg::reg_index_t idx, longint v);
    case (idx)
      iiad_pkg::REG_WINDOW_LENGTH: begin
        win_len_r = v & 'h7f;
        wipe_history();
      end
      iiad_pkg::REG_ACCEL_LIMIT: lim_acc = v & 'h1ffff;
      iiad_pkg::REG_GYRO_LIMIT: lim_rot = v & 'h1ffff;
      iiad_pkg::REG_MAGNET_LIMIT: lim_mag = v & 'h1ffff;
      iiad_pkg::REG_MAGNET_ENABLE: mag_en = v & 1;
      iiad_pkg::REG_SMOOTHING_ENABLE: smooth_en = v & 1;
      iiad_pkg::REG_SMOOTHING_WEIGHT: weight = v & 'h1ff;
      default: ;
    endcase
  endfunction

  function automatic verdict_t predict_verdict(sample_t s);
    longint ax [9];
    longint mg [3];
    longint n, p, alpha, c, imp;
    verdict_t v;
    ax = '{$signed(s.ax), $signed(s.ay), $signed(s.az), $signed(s.gx), $signed(s.gy),
           $signed(s.gz), $signed(s.mx), $signed(s.my), $signed(s.mz)};
    n = (win_len_r < 1) ? 1 : (win_len_r > WinMax ? WinMax : win_len_r);
    if (smooth_en != 0 && filled > 0) begin
      alpha = weight > 256 ? 256 : weight;
      for (int i = 0; i < 9; i++)
        ax[i] = floor256(alpha * ax[i] + (256 - alpha) * prev_axis[i]);
    end
    prev_axis = ax;
    for (int k = 0; k < 3; k++)
      mg[k] = int_sqrt(ax[3*k]*ax[3*k] + ax[3*k+1]*ax[3*k+1] + ax[3*k+2]*ax[3*k+2]);
    p = wr_slot % n;
    if (filled >= n) begin
      for (int k = 0; k < 3; k++) sum_mag[k] -= ring_mag[p][k];
    end else begin
      filled++;
    end
    for (int k = 0; k < 3; k++) begin
      ring_mag[p][k] = mg[k];
      sum_mag[k] += mg[k];
    end
    wr_slot = (p + 1) % n;
    v = '0;
    v.full = filled >= n;
    v.fa = v.full && off_mean(mg[0], sum_mag[0], n, lim_acc);
    v.fr = v.full && off_mean(mg[1], sum_mag[1], n, lim_rot);
    v.ff = v.full && mag_en != 0 && off_mean(mg[2], sum_mag[2], n, lim_mag);
    v.obs = v.fa | v.fr | v.ff;
    if (v.obs) begin
      c = (v.fa ? 40 : 0) + (v.fr ? 30 : 0) + (v.ff ? 30 : 0);
      v.conf = 7'((c > 100) ? 100 : c);
      imp = mg[0] * 70 + mg[1] * 3;
      v.impact = 22'((imp > iiad_pkg::ImpactMax) ? iiad_pkg::ImpactMax : imp);
    end
    return v;
  endfunction

  function automatic logic [15:0] rnd_axis(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // quiet samples with occasional spikes keep the window test meaningful
  function automatic sample_t rnd_sample(int spike);
    sample_t s;
    int base = $urandom_range(0, 3);
    if (spike != 0 || base == 3) begin
      s = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    end else begin
      s.ax = 16'sd1000 + $signed(16'($urandom_range(0, 200)));
      s.ay = $signed(16'($urandom_range(0, 200))) - 16'sd100;
      s.az = $signed(16'($urandom_range(0, 200))) - 16'sd100;
      s.gx = $signed(16'($urandom_range(0, 100)));
      s.gy = $signed(16'($urandom_range(0, 100)));
      s.gz = $signed(16'($urandom_range(0, 100)));
      s.mx = 16'sd500 + $signed(16'($urandom_range(0, 60)));
      s.my = $signed(16'($urandom_range(0, 60)));
      s.mz = $signed(16'($urandom_range(0, 60)));
    end
    return s;
  endfunction

  // driver: transaction accepted at valid && !stall
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        verdict_mem[v_wr] = predict_verdict({acc_x, acc_y, acc_z, rot_x, rot_y, rot_z,
                                             field_x, field_y, field_z});
        v_wr++;
        s_rd++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 0;
        end else if (s_rd < s_wr) begin
          {acc_x, acc_y, acc_z, rot_x, rot_y, rot_z, field_x, field_y, field_z}
            <= sample_mem[s_rd];
          in_valid <= 1;
          // gap after this transaction: mostly short, now and then long
          in_gap = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 90)
                                                 : $urandom_range(0, 2);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_off) begin
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) hold_off <= 0;
    end else if (hold_req) begin
      hold_off <= 1;
      hold_cnt <= HoldCycles;
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {obstacle_found, acc_anomaly, rot_anomaly, field_anomaly,
               confidence_pct, impact_hundredths, history_full};
        if (v_rd == v_wr) begin
          $display("%0t unexpected result %h", $time, got);
          errors++;
        end else begin
          want = verdict_mem[v_rd];
          v_rd++;
          if (got.obs !== want.obs || got.fa !== want.fa || got.fr !== want.fr ||
              got.ff !== want.ff || got.conf !== want.conf ||
              got.impact !== want.impact || got.full !== want.full) begin
            $display("%0t mismatch exp obs%0b a%0b r%0b f%0b c%0d i%0d h%0b",
                     $time, want.obs, want.fa, want.fr, want.ff, want.conf,
                     want.impact, want.full);
            $display("%0t          got obs%0b a%0b r%0b f%0b c%0d i%0d h%0b",
                     $time, got.obs, got.fa, got.fr, got.ff, got.conf,
                     got.impact, got.full);
            errors++;
          end
        end
      end
      if (hold_off) out_stall <= 1;
      else if ($urandom_range(0, 9) < 2) out_stall <= ($urandom_range(0, 1) == 1);
      else out_stall <= ($urandom_range(0, 60) == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || hold_off || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[imu_impact_anomaly_detector_unit] ERROR");
      $finish;
    end
  end

  task automatic write_reg(iiad_pkg::reg_index_t idx, logic [16:0] v);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, v);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (s_rd < s_wr || v_rd < v_wr) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic add_sample(sample_t s);
    sample_mem[s_wr] = s;
    s_wr++;
  endtask

  task automatic burst(int count, int spike_rate);
    for (int i = 0; i < count; i++)
      add_sample(rnd_sample($urandom_range(0, 99) < spike_rate));
  endtask

  initial begin
    sample_t s;
    win_len_r = 16; lim_acc = 4096; lim_rot = 4096; lim_mag = 4096;
    mag_en = 0; smooth_en = 0; weight = 128;
    prev_axis = '{default: 0};
    wipe_history();
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed: extremes of every axis, small window so detection is live
    write_reg(iiad_pkg::REG_WINDOW_LENGTH, 17'd2);
    write_reg(iiad_pkg::REG_MAGNET_ENABLE, 17'd1);
    write_reg(iiad_pkg::REG_ACCEL_LIMIT, 17'd0);
    write_reg(iiad_pkg::REG_GYRO_LIMIT, 17'd0);
    write_reg(iiad_pkg::REG_MAGNET_LIMIT, 17'd0);
    for (int m = 0; m < 4; m++) begin
      for (int k = 0; k < 3; k++) begin
        s = {rnd_axis(m), rnd_axis(m), rnd_axis(m), rnd_axis(m), rnd_axis(m),
             rnd_axis(m), rnd_axis(m), rnd_axis(m), rnd_axis(m)};
        add_sample(s);
      end
    end
    add_sample('0);
    add_sample({9{16'h8000}});
    drain();
    // out-of-range window and weight, smoothing on
    write_reg(iiad_pkg::REG_WINDOW_LENGTH, 17'd0);
    write_reg(iiad_pkg::REG_SMOOTHING_ENABLE, 17'd1);
    write_reg(iiad_pkg::REG_SMOOTHING_WEIGHT, 17'h1ff);
    write_reg(iiad_pkg::reg_index_t'(3'd7), 17'h1ffff);
    burst(4, 50);
    drain();
    write_reg(iiad_pkg::REG_WINDOW_LENGTH, 17'h7f);
    write_reg(iiad_pkg::REG_SMOOTHING_WEIGHT, 17'd0);
    burst(4, 50);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(iiad_pkg::REG_WINDOW_LENGTH,
                17'((ph % 4 == 0) ? 64 : $urandom_range(1, 20)));
      write_reg(iiad_pkg::REG_ACCEL_LIMIT,
                17'((ph == 3) ? 'h1ffff : $urandom_range(0, 400)));
      write_reg(iiad_pkg::REG_GYRO_LIMIT, 17'((ph == 5) ? 0 : $urandom_range(0, 300)));
      write_reg(iiad_pkg::REG_MAGNET_LIMIT, 17'($urandom_range(0, 300)));
      write_reg(iiad_pkg::REG_MAGNET_ENABLE, 17'(ph % 2));
      write_reg(iiad_pkg::REG_SMOOTHING_ENABLE, 17'((ph % 3) == 1));
      write_reg(iiad_pkg::REG_SMOOTHING_WEIGHT,
                17'((ph == 7) ? 256 : $urandom_range(0, 300)));
      burst(150, 8);
      if (ph == 6) begin
        // long receiver hold-off while input keeps coming
        hold_req = 1;
        wait (hold_off);
        hold_req = 0;
        wait (!hold_off);
      end
      drain();
    end
    if (errors == 0)
      $display("[imu_impact_anomaly_detector_unit] OK");
    else
      $display("[imu_impact_anomaly_detector_unit] ERROR");
    $finish;
  end
endmodule

@@ imu_impact_anomaly_detector_unit.f @@
hw/rtl/iiad_pkg.sv
hw/rtl/iiad_ram.sv
hw/rtl/iiad_sqrt.sv
hw/rtl/imu_impact_anomaly_detector_unit.sv
dv/tb_imu_impact_anomaly_detector_unit.sv
